// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an active-low reset that disables it
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// same, on the usual clk / arst_n pair
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, clk, arst_n, prop)

`endif

// ----- rtl/brb_pkg.sv -----
// types and constants of the byte ring buffer
package brb_pkg;

	localparam int CAP_W  = 7;
	localparam int LEN_W  = 16;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_PICK = 1'b1;

	localparam logic [IDX_W-1:0] CFG_CAPACITY  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_OVERWRITE = 2'd1;
	localparam logic [IDX_W-1:0] CFG_REALTIME  = 2'd2;

	localparam logic [1:0] ST_PUT_OK     = 2'd0;
	localparam logic [1:0] ST_PUT_REJ    = 2'd1;
	localparam logic [1:0] ST_PICK_BYTE  = 2'd2;
	localparam logic [1:0] ST_PICK_EMPTY = 2'd3;

	// output queue depth
	localparam logic [1:0] OQ_DEPTH = 2'd2;

	typedef enum logic [0:0] {
		S_IDLE,
		S_PICK
	} brb_state_t;

	typedef struct packed {
		logic              opcode;
		logic              first_byte;
		logic              last_byte;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0]  length;
	} brb_in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] out_byte;
		logic [CAP_W-1:0]  moved_count;
		logic              final_res;
	} brb_out_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic             overwrite_mode;
		logic             realtime_mode;
	} brb_cfg_t;

	typedef struct packed {
		logic     valid;
		brb_out_t beat;
	} brb_push_t;

	typedef struct packed {
		logic [1:0] count;
		logic       pop;
	} brb_oq_stat_t;

endpackage

// ----- rtl/brb_if.sv -----
// valid/ready channel interfaces for input and result beats
interface brb_in_if import brb_pkg::*;;
	logic    valid;
	logic    ready;
	brb_in_t beat;

	modport source(output valid, output beat, input ready);
	modport sink(input valid, input beat, output ready);
endinterface

interface brb_out_if import brb_pkg::*;;
	logic     valid;
	logic     ready;
	brb_out_t beat;

	modport source(output valid, output beat, input ready);
	modport sink(input valid, input beat, output ready);
endinterface

// ----- rtl/brb_ram.sv -----
// generic single-write, single-read ram with registered read data
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/brb_outq.sv -----
// two-entry result queue between the control logic and the output channel
module brb_outq import brb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  brb_push_t    push,
	output logic         out_valid,
	output brb_out_t     out_beat,
	input  logic         out_ready,
	output brb_oq_stat_t stat
);

	logic [1:0] count_q;
	brb_out_t   entry0_q;
	brb_out_t   entry1_q;
	logic       pop;

	assign out_valid  = (count_q != 2'd0);
	assign out_beat   = entry0_q;
	assign pop        = out_valid && out_ready;
	assign stat.count = count_q;
	assign stat.pop   = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == OQ_DEPTH) begin
				entry0_q <= entry1_q;
				if (push.valid) begin
					entry1_q <= push.beat;
				end
			end else if (push.valid) begin
				entry0_q <= push.beat;
			end
		end else if (push.valid) begin
			if (count_q == 2'd0) begin
				entry0_q <= push.beat;
			end else begin
				entry1_q <= push.beat;
			end
		end
	end

endmodule

// ----- rtl/brb_ctrl.sv -----
// ring pointers, message tracking and pick sequencer around the byte store
module brb_ctrl import brb_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  brb_in_t           in_beat,
	input  logic              in_valid,
	output logic              in_ready,
	input  brb_cfg_t          cfg,
	input  brb_oq_stat_t      oq,
	output brb_push_t         push,
	output logic              ram_we,
	output logic [PTR_W-1:0]  ram_waddr,
	output logic [BYTE_W-1:0] ram_wdata,
	output logic              ram_re,
	output logic [PTR_W-1:0]  ram_raddr,
	input  logic [BYTE_W-1:0] ram_rdata
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WIDE_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

	brb_state_t       state_q, state_d;
	logic [PTR_W-1:0] rp_q, wp_q;
	logic [CNT_W-1:0] fill_q;
	logic             msg_acc_q;
	logic [CAP_W-1:0] msg_left_q, msg_len_q;
	logic [CNT_W-1:0] pick_left_q, pick_n_q;
	logic             rd_valid_s1, rd_last_s1;

	logic [WIDE_W-1:0] cap_w, len_w, fill_w;
	logic              accept, is_put, is_pick;
	logic              fits, len_ok, acc_start, put_clear;
	logic              msg_acc_e;
	logic [CAP_W-1:0]  msg_left_e, msg_len_e, msg_left_after;
	logic [PTR_W-1:0]  wp_e, rp_e;
	logic [CNT_W-1:0]  fill_e;
	logic              do_write;
	logic              pick_empty;
	logic [CNT_W-1:0]  pick_n;
	logic              can_issue, issue, last_issue;

	// next position, wrapping at the effective capacity
	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] pos,
		input logic [WIDE_W-1:0] cap);
		logic [WIDE_W-1:0] nxt;
		nxt = WIDE_W'(pos) + WIDE_W'(1);
		if (nxt >= cap || nxt >= WIDE_W'(DEPTH)) begin
			adv = '0;
		end else begin
			adv = PTR_W'(nxt);
		end
	endfunction

	always_comb begin
		cap_w  = (WIDE_W'(cfg.capacity) > WIDE_W'(DEPTH)) ? WIDE_W'(DEPTH)
			: WIDE_W'(cfg.capacity);
		len_w  = WIDE_W'(in_beat.length);
		fill_w = WIDE_W'(fill_q);

		accept  = in_valid && in_ready;
		is_put  = accept && (in_beat.opcode == OP_PUT);
		is_pick = accept && (in_beat.opcode == OP_PICK);

		fits      = (fill_w + len_w) <= cap_w;
		len_ok    = (in_beat.length != '0) && (len_w <= cap_w);
		acc_start = in_beat.first_byte && len_ok && (fits || cfg.overwrite_mode);
		put_clear = acc_start && !fits;

		msg_acc_e  = in_beat.first_byte ? acc_start : msg_acc_q;
		msg_left_e = in_beat.first_byte ? (acc_start ? CAP_W'(in_beat.length) : '0)
			: msg_left_q;
		msg_len_e  = in_beat.first_byte ? (acc_start ? CAP_W'(in_beat.length) : '0)
			: msg_len_q;

		wp_e   = put_clear ? '0 : wp_q;
		rp_e   = put_clear ? '0 : rp_q;
		fill_e = put_clear ? '0 : fill_q;

		do_write       = msg_acc_e && (msg_left_e != '0);
		msg_left_after = do_write ? (msg_left_e - CAP_W'(1)) : msg_left_e;

		pick_empty = (in_beat.length == '0) || (fill_q == '0);
		pick_n     = (len_w < fill_w) ? CNT_W'(in_beat.length) : fill_q;

		// a read is issued only when its data has a queue slot waiting
		can_issue  = (({1'b0, oq.count} + {2'b0, rd_valid_s1}) < {1'b0, OQ_DEPTH})
			|| oq.pop;
		issue      = (state_q == S_PICK) && can_issue;
		last_issue = issue && (pick_left_q == CNT_W'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (is_pick && !pick_empty) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (last_issue) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = (state_q == S_IDLE) && !rd_valid_s1 && (oq.count < OQ_DEPTH);
		ram_re    = issue;
		ram_raddr = rp_q;
		ram_we    = is_put && do_write;
		ram_waddr = wp_e;
		ram_wdata = in_beat.data_byte;

		push.valid            = 1'b0;
		push.beat.status      = ST_PUT_REJ;
		push.beat.out_byte    = '0;
		push.beat.moved_count = '0;
		push.beat.final_res   = 1'b1;
		if (rd_valid_s1) begin
			push.valid            = 1'b1;
			push.beat.status      = ST_PICK_BYTE;
			push.beat.out_byte    = ram_rdata;
			push.beat.moved_count = CAP_W'(pick_n_q);
			push.beat.final_res   = rd_last_s1;
		end else if (is_put && in_beat.last_byte) begin
			push.valid = 1'b1;
			if (msg_acc_e) begin
				push.beat.status      = ST_PUT_OK;
				push.beat.moved_count = msg_len_e - msg_left_after;
			end
		end else if (is_pick && pick_empty) begin
			push.valid       = 1'b1;
			push.beat.status = ST_PICK_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rp_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			msg_acc_q   <= 1'b0;
			msg_left_q  <= '0;
			msg_len_q   <= '0;
			pick_left_q <= '0;
			pick_n_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			rd_last_s1  <= last_issue;

			if (is_put) begin
				wp_q   <= do_write ? adv(wp_e, cap_w) : wp_e;
				rp_q   <= rp_e;
				fill_q <= (do_write && fill_e < CNT_W'(DEPTH)) ? fill_e + CNT_W'(1)
					: fill_e;
				if (in_beat.last_byte) begin
					msg_acc_q  <= 1'b0;
					msg_left_q <= '0;
					msg_len_q  <= '0;
				end else begin
					msg_acc_q  <= msg_acc_e;
					msg_left_q <= msg_left_after;
					msg_len_q  <= msg_len_e;
				end
			end

			if (is_pick && !pick_empty) begin
				pick_left_q <= pick_n;
				pick_n_q    <= pick_n;
			end

			if (issue) begin
				pick_left_q <= pick_left_q - CNT_W'(1);
				// realtime mode empties the ring after the last read of a pick
				if (last_issue && cfg.realtime_mode) begin
					rp_q   <= '0;
					wp_q   <= '0;
					fill_q <= '0;
				end else begin
					rp_q   <= adv(rp_q, cap_w);
					fill_q <= fill_q - CNT_W'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/byte_ring_buffer_top.sv -----
// top level of the byte ring buffer: config registers, store, control and result queue
//
// in_ch carries one beat per put byte or pick request; out_ch returns result beats.
// a put message is sent byte by byte, first_byte marks the byte carrying its length;
// only the beat marked last_byte yields a result (accepted count or rejected).
// a pick request yields min(length, fill) picked-byte beats in fifo order, or one
// empty beat; final_res flags the last beat of each request.
// put bytes are taken one per cycle while no pick runs and the result queue has room;
// a put result is registered in that queue. a pick of n bytes reads the store once
// per cycle through its single read port while the queue has room; each byte passes
// the registered read and the queue, and no input beat is taken before the last one
// is queued. the two-entry queue sits in front of out_ch; a stalled receiver holds off
// input once the queue is full and reads once it would fill; nothing is dropped.
// reset clears pointers, fill count and message tracking at once; the store keeps
// its contents, which are never read before being written, so no clearing pass.
// config writes (cfg_we, cfg_index, cfg_data) are meant for idle periods only.
module byte_ring_buffer_top import brb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	brb_in_if.sink            in_ch,
	brb_out_if.source         out_ch,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CAP_W-1:0]  cfg_data
);

	localparam int PTR_W = $clog2(DEPTH);

	brb_cfg_t          cfg_q;
	brb_oq_stat_t      oq_stat;
	brb_push_t         push;
	logic              ram_we, ram_re;
	logic [PTR_W-1:0]  ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	// configuration registers, write only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity       <= CAP_RESET;
			cfg_q.overwrite_mode <= 1'b0;
			cfg_q.realtime_mode  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY:  cfg_q.capacity       <= cfg_data;
				CFG_OVERWRITE: cfg_q.overwrite_mode <= cfg_data[0];
				CFG_REALTIME:  cfg_q.realtime_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// byte store
	brb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// pointers, message state and pick sequencing
	brb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (in_ch.beat),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cfg      (cfg_q),
		.oq       (oq_stat),
		.push     (push),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// result queue decouples the receiver from the store read pipeline
	brb_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.out_valid(out_ch.valid),
		.out_beat (out_ch.beat),
		.out_ready(out_ch.ready),
		.stat     (oq_stat)
	);

endmodule

// ----- rtl/brb_checker.sv -----
// port-level checks of the byte ring buffer, bound to the top level
`include "assert_macros.svh"

module brb_checker import brb_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input brb_in_t  in_beat,
	input logic     out_valid,
	input logic     out_ready,
	input brb_out_t out_beat
);

	// a stalled result beat stays put
	`ASSERT_STD(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat))

	// only picked bytes carry data
	`ASSERT_STD(a_no_stray_byte, out_valid && out_beat.status != ST_PICK_BYTE |-> out_beat.out_byte == '0 && out_beat.final_res)

	// input stays blocked while a pick is still being delivered
	`ASSERT_STD(a_pick_blocks_input, out_valid && out_beat.status == ST_PICK_BYTE && !out_beat.final_res |-> !in_ready)

	// the last byte of a put reports on the next cycle
	`ASSERT_STD(a_put_reports, in_valid && in_ready && in_beat.opcode == OP_PUT && in_beat.last_byte |=> out_valid)

endmodule

bind byte_ring_buffer_top brb_checker u_brb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_beat  (in_ch.beat),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_beat (out_ch.beat)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// testbench of the byte ring buffer: directed table, then randomized phases checked on the fly
module testbench;
	import brb_pkg::*;

	// one row of the directed table: the input beat and, where it is obvious, its result
	typedef struct packed {
		bit       typed;
		brb_in_t  beat;
		brb_out_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0] cfg_data;

	brb_in_if  in_ch();
	brb_out_if out_ch();

	byte_ring_buffer_top #(.DEPTH(64)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ring model state, kept at the block's own widths
	logic [7:0]       ring_mem [64];
	logic [5:0]       rd_ptr;
	logic [5:0]       wr_ptr;
	logic [6:0]       fill;
	logic             msg_open;
	logic [6:0]       msg_left;
	logic [6:0]       msg_len;
	logic [CAP_W-1:0] cfg_capacity;
	logic             cfg_overwrite;
	logic             cfg_realtime;

	// results of the latest beat, and all results still owed by the block
	brb_out_t ring_results [$];
	brb_out_t pending_out [$];
	stim_row_t directed_rows [$];

	int fail_count;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int hold_left;

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("[byte_ring_buffer_top] ERROR");
		$finish;
	end

	// capacity as the block uses it: above the built depth it saturates
	function automatic int eff_cap();
		return (cfg_capacity > 7'd64) ? 64 : int'(cfg_capacity);
	endfunction

	// pointer advance, wraps at the capacity in use or at the built depth
	function automatic logic [5:0] next_pos(input logic [5:0] p);
		int nx;
		nx = int'(p) + 1;
		if (nx >= eff_cap() || nx >= 64)
			nx = 0;
		return nx[5:0];
	endfunction

	function automatic void clear_ring();
		rd_ptr = '0;
		wr_ptr = '0;
		fill   = '0;
	endfunction

	// state update for one accepted input beat; result beats go to ring_results
	function automatic void ring_apply(input brb_in_t it);
		int cap;
		int n;
		bit fits;
		brb_out_t r;
		ring_results.delete();
		cap = eff_cap();
		if (it.opcode == OP_PUT) begin
			// a first byte always drops whatever message was open
			if (it.first_byte) begin
				msg_open = 1'b0;
				msg_left = '0;
				msg_len  = '0;
				if (it.length != 0 && int'(it.length) <= cap) begin
					fits = (int'(fill) + int'(it.length)) <= cap;
					if (fits || cfg_overwrite) begin
						if (!fits)
							clear_ring();
						msg_open = 1'b1;
						msg_left = it.length[6:0];
						msg_len  = it.length[6:0];
					end
				end
			end
			// bytes past the announced length fall through
			if (msg_open && msg_left != 0) begin
				ring_mem[wr_ptr] = it.data_byte;
				wr_ptr = next_pos(wr_ptr);
				if (fill < 7'd64)
					fill = fill + 7'd1;
				msg_left = msg_left - 7'd1;
			end
			if (it.last_byte) begin
				r.status      = msg_open ? ST_PUT_OK : ST_PUT_REJ;
				r.out_byte    = '0;
				r.moved_count = msg_open ? (msg_len - msg_left) : 7'd0;
				r.final_res   = 1'b1;
				ring_results.push_back(r);
				msg_open = 1'b0;
				msg_left = '0;
				msg_len  = '0;
			end
		end else if (it.length == 0 || fill == 0) begin
			r.status      = ST_PICK_EMPTY;
			r.out_byte    = '0;
			r.moved_count = '0;
			r.final_res   = 1'b1;
			ring_results.push_back(r);
		end else begin
			n = (int'(it.length) < int'(fill)) ? int'(it.length) : int'(fill);
			for (int k = 0; k < n; k++) begin
				r.status      = ST_PICK_BYTE;
				r.out_byte    = ring_mem[rd_ptr];
				r.moved_count = n[6:0];
				r.final_res   = (k == n - 1);
				ring_results.push_back(r);
				rd_ptr = next_pos(rd_ptr);
			end
			fill = fill - n[6:0];
			if (cfg_realtime)
				clear_ring();
		end
	endfunction

	// offer one beat from a falling edge, hold it until taken, then book its results
	task automatic send_beat(input brb_in_t it, input bit typed, input brb_out_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.beat  <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		ring_apply(it);
		if (typed)
			pending_out.push_back(typed_res);
		else
			foreach (ring_results[k])
				pending_out.push_back(ring_results[k]);
		@(negedge clk);
	endtask

	// input side quiet and every owed beat in, plus a margin for trailing work
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// all three registers, one per cycle, only while the block is idle
	task automatic write_settings(input logic [6:0] cap, input logic ow, input logic rt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_data  <= cap;
		@(negedge clk);
		cfg_index <= CFG_OVERWRITE;
		cfg_data  <= {6'd0, ow};
		@(negedge clk);
		cfg_index <= CFG_REALTIME;
		cfg_data  <= {6'd0, rt};
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_capacity  = cap;
		cfg_overwrite = ow;
		cfg_realtime  = rt;
	endtask

	function automatic void add_row(input logic op, input logic f, input logic l,
			input logic [7:0] d, input logic [15:0] len,
			input bit typed, input logic [1:0] st, input logic [6:0] cnt);
		stim_row_t row;
		row.typed            = typed;
		row.beat.opcode      = op;
		row.beat.first_byte  = f;
		row.beat.last_byte   = l;
		row.beat.data_byte   = d;
		row.beat.length      = len;
		row.res.status       = st;
		row.res.out_byte     = '0;
		row.res.moved_count  = cnt;
		row.res.final_res    = 1'b1;
		directed_rows.push_back(row);
	endfunction

	// random mix: mostly well-formed messages, picks of all sizes, some loose beats
	task automatic random_traffic(input int beats);
		int done;
		int sel;
		int lim;
		int mlen;
		int sent;
		brb_in_t it;
		done = 0;
		while (done < beats) begin
			sel = $urandom_range(99);
			if (sel < 55) begin
				lim = (eff_cap() > 6) ? 6 : eff_cap();
				sel = $urandom_range(99);
				if (sel < 10) begin
					// length that is refused, or any random 16-bit length
					case ($urandom_range(2))
						0: mlen = 0;
						1: mlen = eff_cap() + 1;
						default: mlen = $urandom_range(65535);
					endcase
				end else if (sel < 15 && eff_cap() > 0)
					mlen = eff_cap();
				else if (lim == 0)
					mlen = $urandom_range(3);
				else
					mlen = $urandom_range(lim, 1);
				sent = (mlen == 0) ? 1 : mlen;
				if (sent > 64)
					sent = $urandom_range(4, 1);
				// short and overlong messages
				sel = $urandom_range(99);
				if (sel < 10 && sent > 1)
					sent = $urandom_range(sent - 1, 1);
				else if (sel < 20)
					sent = sent + $urandom_range(3, 1);
				for (int i = 0; i < sent; i++) begin
					it.opcode     = OP_PUT;
					it.first_byte = (i == 0);
					it.last_byte  = (i == sent - 1);
					it.data_byte  = 8'($urandom);
					it.length     = (i == 0) ? mlen[15:0] : 16'($urandom);
					send_beat(it, 1'b0, '0);
				end
				done += sent;
			end else if (sel < 85) begin
				it.opcode     = OP_PICK;
				it.first_byte = 1'($urandom);
				it.last_byte  = 1'($urandom);
				it.data_byte  = 8'($urandom);
				sel = $urandom_range(99);
				if (sel < 40)
					it.length = 16'($urandom_range(8));
				else if (sel < 70)
					it.length = 16'($urandom_range(64, 1));
				else if (sel < 80)
					it.length = 16'hffff;
				else if (sel < 90)
					it.length = 16'($urandom);
				else
					it.length = '0;
				send_beat(it, 1'b0, '0);
				done++;
			end else begin
				// loose put beat with random framing bits
				it.opcode     = OP_PUT;
				it.first_byte = 1'($urandom);
				it.last_byte  = 1'($urandom);
				it.data_byte  = 8'($urandom);
				it.length     = ($urandom_range(1)) ? 16'($urandom_range(70)) : 16'($urandom);
				send_beat(it, 1'b0, '0);
				done++;
			end
		end
	endtask

	// one phase: empty the ring, retune the registers, then random beats
	task automatic run_phase(input logic [6:0] cap, input logic ow, input logic rt,
			input int sidle, input int rstall, input bit hold, input int beats);
		brb_in_t it;
		// emptying first keeps every later read on a written entry
		if (fill != 0) begin
			it.opcode     = OP_PICK;
			it.first_byte = 1'b0;
			it.last_byte  = 1'b0;
			it.data_byte  = '0;
			it.length     = 16'hffff;
			send_beat(it, 1'b0, '0);
		end
		settle();
		write_settings(cap, ow, rt);
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		if (hold)
			hold_request = 1'b1;
		random_traffic(beats);
	endtask

	// result side: random stalls, plus one long hold-off counted here
	initial begin
		out_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// every result beat against the oldest owed one
	always @(posedge clk) begin
		brb_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected result beat status %0d byte %h count %0d final %0b",
					$time, out_ch.beat.status, out_ch.beat.out_byte,
					out_ch.beat.moved_count, out_ch.beat.final_res);
				fail_count++;
			end else begin
				want = pending_out.pop_front();
				if (out_ch.beat.status !== want.status ||
						out_ch.beat.out_byte !== want.out_byte ||
						out_ch.beat.moved_count !== want.moved_count ||
						out_ch.beat.final_res !== want.final_res) begin
					$display("%0t: expected status %0d byte %h count %0d final %0b, got status %0d byte %h count %0d final %0b",
						$time, want.status, want.out_byte, want.moved_count, want.final_res,
						out_ch.beat.status, out_ch.beat.out_byte,
						out_ch.beat.moved_count, out_ch.beat.final_res);
					fail_count++;
				end
			end
		end
	end

	initial begin
		// known values on every input from time zero
		arst_n      = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.beat  = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_CAPACITY;
		cfg_data    = '0;
		fail_count     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;

		// model state after reset
		cfg_capacity  = CAP_RESET;
		cfg_overwrite = 1'b0;
		cfg_realtime  = 1'b0;
		clear_ring();
		msg_open = 1'b0;
		msg_left = '0;
		msg_len  = '0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, reset settings: capacity 64, no overwrite, no realtime
		//        op       first last data   length   typed status         count
		add_row(OP_PICK, 1'b0, 1'b0, 8'h00, 16'd5,    1, ST_PICK_EMPTY, 7'd0); // pick on empty ring
		add_row(OP_PUT,  1'b0, 1'b1, 8'h5a, 16'd0,    1, ST_PUT_REJ,    7'd0); // last byte, no message open
		add_row(OP_PUT,  1'b1, 1'b1, 8'h01, 16'd0,    1, ST_PUT_REJ,    7'd0); // zero length
		add_row(OP_PUT,  1'b1, 1'b1, 8'h02, 16'hffff, 1, ST_PUT_REJ,    7'd0); // largest length
		add_row(OP_PUT,  1'b1, 1'b1, 8'h03, 16'd65,   1, ST_PUT_REJ,    7'd0); // one above capacity
		add_row(OP_PUT,  1'b1, 1'b0, 8'h00, 16'd3,    0, ST_PUT_OK,     7'd0); // three-byte message
		add_row(OP_PUT,  1'b0, 1'b0, 8'hff, 16'hffff, 0, ST_PUT_OK,     7'd0);
		add_row(OP_PUT,  1'b0, 1'b1, 8'ha5, 16'd0,    1, ST_PUT_OK,     7'd3);
		add_row(OP_PICK, 1'b1, 1'b1, 8'hff, 16'd0,    1, ST_PICK_EMPTY, 7'd0); // zero-length pick
		add_row(OP_PUT,  1'b1, 1'b0, 8'h11, 16'd4,    0, ST_PUT_OK,     7'd0); // short message
		add_row(OP_PUT,  1'b0, 1'b1, 8'h22, 16'd0,    1, ST_PUT_OK,     7'd2);
		add_row(OP_PUT,  1'b1, 1'b0, 8'h33, 16'd2,    0, ST_PUT_OK,     7'd0); // bytes past length
		add_row(OP_PUT,  1'b0, 1'b0, 8'h44, 16'd0,    0, ST_PUT_OK,     7'd0);
		add_row(OP_PUT,  1'b0, 1'b0, 8'h55, 16'd0,    0, ST_PUT_OK,     7'd0);
		add_row(OP_PUT,  1'b0, 1'b1, 8'h66, 16'd0,    1, ST_PUT_OK,     7'd2);
		add_row(OP_PUT,  1'b1, 1'b0, 8'h77, 16'd5,    0, ST_PUT_OK,     7'd0); // abandoned by a new first
		add_row(OP_PUT,  1'b1, 1'b1, 8'h88, 16'd1,    1, ST_PUT_OK,     7'd1);
		add_row(OP_PUT,  1'b0, 1'b1, 8'h99, 16'd0,    1, ST_PUT_REJ,    7'd0); // stray last byte
		add_row(OP_PICK, 1'b0, 1'b0, 8'h00, 16'd1,    0, ST_PICK_BYTE,  7'd0);
		add_row(OP_PICK, 1'b0, 1'b0, 8'h00, 16'hffff, 0, ST_PICK_BYTE,  7'd0); // drains the rest
		add_row(OP_PUT,  1'b1, 1'b1, 8'hc3, 16'd64,   1, ST_PUT_OK,     7'd1); // full-capacity length
		add_row(OP_PUT,  1'b1, 1'b1, 8'h3c, 16'd64,   1, ST_PUT_REJ,    7'd0); // does not fit
		add_row(OP_PICK, 1'b0, 1'b0, 8'h00, 16'hffff, 0, ST_PICK_BYTE,  7'd0);
		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);

		// random phases over register settings and idle patterns
		//        cap      ow    rt    sidle rstall hold beats
		run_phase(7'd64,  1'b0, 1'b0, 0,  0,  1, 14); // long receiver hold-off, sender keeps offering
		run_phase(7'd8,   1'b1, 1'b0, 74, 0,  0, 14);
		run_phase(7'd1,   1'b0, 1'b0, 0,  74, 0, 14);
		run_phase(7'd64,  1'b1, 1'b1, 8,  8,  0, 14);
		run_phase(7'd0,   1'b0, 1'b0, 74, 0,  0, 8); // every put refused
		run_phase(7'd127, 1'b0, 1'b1, 0,  74, 0, 14); // saturates at the built depth
		run_phase(7'd20,  1'b1, 1'b0, 8,  8,  0, 14);
		run_phase(7'd4,   1'b0, 1'b0, 0,  0,  0, 14);
		run_phase(7'd64,  1'b1, 1'b0, 74, 74, 0, 14);

		// wind down: every owed beat in, then a margin
		in_ch.valid <= 1'b0;
		while (pending_out.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("[byte_ring_buffer_top] OK");
		else
			$display("[byte_ring_buffer_top] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/brb_pkg.sv
rtl/brb_if.sv
rtl/brb_ram.sv
rtl/brb_outq.sv
rtl/brb_ctrl.sv
rtl/byte_ring_buffer_top.sv
rtl/brb_checker.sv
tb/testbench.sv
